// File: rtl/cfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared constants, types and the hash function of the cuckoo filter engine.
// ----------------------------------------------------------------------------
package cfe_pkg;

    localparam int SLOTS   = 128;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FP_W    = 16;
    localparam int CNT_W   = 8;
    localparam int KEY_W   = 16;

    localparam logic [FP_W-1:0]  DJB_SEED    = 16'd5381;
    localparam int               DJB_SHIFT   = 5;
    localparam logic [FP_W-1:0]  SLOT_MASK   = FP_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef logic [FP_W-1:0]   t_fp;
    typedef logic [SLOT_W-1:0] t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    // read address select
    typedef logic [1:0] t_rd_sel;
    localparam t_rd_sel RD_I1  = 2'd0;
    localparam t_rd_sel RD_I2  = 2'd1;
    localparam t_rd_sel RD_ALT = 2'd2;

    typedef struct packed {
        logic    load;      // capture input transaction
        logic    fp_en;     // fingerprint of the key
        logic    idx_en;    // both candidate slots
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    d1_en;     // hold first slot contents
        logic    ins1;      // fingerprint into first slot
        logic    ins2;      // fingerprint into second slot
        logic    evict;     // fingerprint over a full slot, keep its victim
        logic    alt_en;    // alternate slot of the victim
        logic    place;     // victim into an empty slot
        logic    swap;      // victim over an occupied slot, carry on
        logic    set_ok;
        logic    ok_val;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic is_lookup;
        logic hit;
        logic d1_empty;
        logic d2_empty;
        logic held_empty;
        logic limit_hit;
    } t_sts;

    function automatic t_fp djb16(input logic [15:0] w);
        t_fp h;
        h = DJB_SEED;
        h = (h << DJB_SHIFT) + h + {8'd0, w[7:0]};
        h = (h << DJB_SHIFT) + h + {8'd0, w[15:8]};
        return h;
    endfunction

    function automatic t_idx slot_of(input t_fp w);
        t_fp m;
        m = w & SLOT_MASK;
        return m[SLOT_W-1:0];
    endfunction

endpackage

// File: rtl/cfe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_datapath
// Fingerprint table, hashing, relocation registers and result registers.
// ----------------------------------------------------------------------------
module cfe_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cfe_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                       i_op,
    input  logic [cfe_pkg::KEY_W-1:0]  i_key,
    input  logic                       i_evict_second,
    input  cfe_pkg::t_cmd              i_cmd,
    output cfe_pkg::t_sts              o_sts,
    output logic                       o_ok,
    output logic [cfe_pkg::CNT_W-1:0]  o_relocations_used
);

    logic                      r_op;
    logic [cfe_pkg::KEY_W-1:0] r_key;
    logic                      r_evict;
    cfe_pkg::t_fp              r_fp;
    cfe_pkg::t_idx             r_i1;
    cfe_pkg::t_idx             r_i2;
    cfe_pkg::t_idx             r_at;
    cfe_pkg::t_idx             r_alt;
    cfe_pkg::t_fp              r_victim;
    cfe_pkg::t_fp              r_d1;
    cfe_pkg::t_cnt             r_cnt;
    cfe_pkg::t_cnt             r_limit;
    logic                      r_ok;
    logic                      r_o_ok;
    cfe_pkg::t_cnt             r_o_cnt;

    cfe_pkg::t_fp              r_mem [cfe_pkg::SLOTS];
    logic [cfe_pkg::SLOTS-1:0] r_vld;
    cfe_pkg::t_fp              r_rdata;
    logic                      r_rvld;

    cfe_pkg::t_idx             rd_addr;
    cfe_pkg::t_fp              rd_data;
    logic                      wr_en;
    cfe_pkg::t_idx             wr_addr;
    cfe_pkg::t_fp              wr_data;
    cfe_pkg::t_idx             evict_at;

    // slot without a valid bit has never been written since reset: empty
    assign rd_data  = r_rvld ? r_rdata : '0;
    assign evict_at = r_evict ? r_i2 : r_i1;

    always_comb begin
        unique case (i_cmd.rd_sel)
            cfe_pkg::RD_I1: rd_addr = r_i1;
            cfe_pkg::RD_I2: rd_addr = r_i2;
            default:        rd_addr = r_alt;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_alt;
        wr_data = r_victim;
        priority if (i_cmd.ins1) begin
            wr_addr = r_i1;
            wr_data = r_fp;
        end else if (i_cmd.ins2) begin
            wr_addr = r_i2;
            wr_data = r_fp;
        end else if (i_cmd.evict) begin
            wr_addr = evict_at;
            wr_data = r_fp;
        end else if (i_cmd.place || i_cmd.swap) begin
            wr_addr = r_alt;
            wr_data = r_victim;
        end else begin
            wr_en = 1'b0;
        end
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_rvld  <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= cfe_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_evict <= i_evict_second;
            r_cnt   <= '0;
        end
        if (i_cmd.fp_en) begin
            r_fp <= cfe_pkg::djb16(r_key);
        end
        if (i_cmd.idx_en) begin
            r_i1 <= cfe_pkg::slot_of(r_fp);
            r_i2 <= cfe_pkg::slot_of(r_fp) ^ cfe_pkg::slot_of(cfe_pkg::djb16(r_fp));
        end
        if (i_cmd.d1_en) begin
            r_d1 <= rd_data;
        end
        if (i_cmd.evict) begin
            r_at     <= evict_at;
            r_victim <= r_evict ? rd_data : r_d1;
        end
        if (i_cmd.alt_en) begin
            r_alt <= r_at ^ cfe_pkg::slot_of(cfe_pkg::djb16(r_victim));
        end
        if (i_cmd.swap) begin
            r_cnt    <= r_cnt + 1'b1;
            r_victim <= rd_data;
            r_at     <= r_alt;
        end
        if (i_cmd.set_ok) begin
            r_ok <= i_cmd.ok_val;
        end
        if (i_cmd.out_load) begin
            r_o_ok  <= r_ok;
            r_o_cnt <= r_cnt;
        end
    end

    always_comb begin
        o_sts.is_lookup  = (r_op == cfe_pkg::OP_LOOKUP);
        o_sts.hit        = (r_d1 == r_fp) || (rd_data == r_fp);
        o_sts.d1_empty   = (r_d1 == '0);
        o_sts.d2_empty   = (rd_data == '0);
        o_sts.held_empty = (rd_data == '0);
        o_sts.limit_hit  = (r_cnt >= r_limit);
    end

    assign o_ok               = r_o_ok;
    assign o_relocations_used = r_o_cnt;

    a_load_clears_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_cnt == '0)
        else $error("relocation count not cleared on new transaction");

    a_swap_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.swap |-> r_cnt < r_limit)
        else $error("relocation taken at or past the limit");

    a_one_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({i_cmd.ins1, i_cmd.ins2, i_cmd.evict, i_cmd.place, i_cmd.swap}) <= 1)
        else $error("more than one table write source in a cycle");

endmodule

// File: rtl/cfe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_ctrl
// Sequencer for lookup, insert and the relocation walk; owns the output valid.
// ----------------------------------------------------------------------------
module cfe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  cfe_pkg::t_sts i_sts,
    output cfe_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FP   = 4'd1;
    localparam logic [3:0] S_IDX  = 4'd2;
    localparam logic [3:0] S_RD1  = 4'd3;
    localparam logic [3:0] S_RD2  = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_ALT  = 4'd6;
    localparam logic [3:0] S_RDA  = 4'd7;
    localparam logic [3:0] S_HELD = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_vld;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FP;
                end
            end
            S_FP: begin
                o_cmd.fp_en = 1'b1;
                n_state     = S_IDX;
            end
            S_IDX: begin
                o_cmd.idx_en = 1'b1;
                n_state      = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = cfe_pkg::RD_I1;
                n_state      = S_RD2;
            end
            S_RD2: begin
                o_cmd.d1_en  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = cfe_pkg::RD_I2;
                n_state      = S_CHK;
            end
            S_CHK: begin
                priority if (i_sts.is_lookup) begin
                    o_cmd.set_ok = 1'b1;
                    o_cmd.ok_val = i_sts.hit;
                    n_state      = S_DONE;
                end else if (i_sts.d1_empty) begin
                    o_cmd.ins1   = 1'b1;
                    o_cmd.set_ok = 1'b1;
                    o_cmd.ok_val = 1'b1;
                    n_state      = S_DONE;
                end else if (i_sts.d2_empty) begin
                    o_cmd.ins2   = 1'b1;
                    o_cmd.set_ok = 1'b1;
                    o_cmd.ok_val = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.evict = 1'b1;
                    n_state     = S_ALT;
                end
            end
            S_ALT: begin
                o_cmd.alt_en = 1'b1;
                n_state      = S_RDA;
            end
            S_RDA: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = cfe_pkg::RD_ALT;
                n_state      = S_HELD;
            end
            S_HELD: begin
                priority if (i_sts.held_empty) begin
                    o_cmd.place  = 1'b1;
                    o_cmd.set_ok = 1'b1;
                    o_cmd.ok_val = 1'b1;
                    n_state      = S_DONE;
                end else if (i_sts.limit_hit) begin
                    // displaced victim is dropped
                    o_cmd.set_ok = 1'b1;
                    o_cmd.ok_val = 1'b0;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.swap = 1'b1;
                    n_state    = S_ALT;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_state == S_FP)
        else $error("accepted transaction did not start hashing");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_vld || i_ready)) |=> (r_out_vld && r_state == S_IDLE))
        else $error("finished transaction not moved to output register");

    a_lookup_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && i_sts.is_lookup) |=> r_state == S_DONE)
        else $error("lookup entered the relocation walk");

    a_walk_ends_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HELD && i_sts.held_empty) |-> (o_cmd.place && o_cmd.ok_val))
        else $error("victim not placed in an empty slot");

endmodule

// File: rtl/cuckoo_filter_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuckoo_filter_engine
// Cuckoo filter over a 128-entry table of 16-bit DJB fingerprints.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries i_op (0 insert, 1 lookup), i_key
//   and i_evict_second. Output channel (o_valid/i_ready) returns o_ok and
//   o_relocations_used, one result per input transaction, in order.
//   i_cfg_we/i_cfg_wdata write the relocation limit (reset value 8); write
//   it only while the engine is idle.
//   One transaction is handled at a time. An insert that evicts runs up to
//   limit + 1 relocation steps, each a hash, a table read and a
//   compare/write. The single-port table read with registered data sets
//   the step length. o_ready returns in the cycle o_valid rises.
//   Reset clears the table at once through per-entry valid bits; the engine
//   is ready in the first cycle after reset.
//   The result register lets a new transaction be accepted while a result
//   waits; if the receiver stalls, the next result holds in the engine until
//   the output register frees up.
// ----------------------------------------------------------------------------
module cuckoo_filter_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cfe_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_op,
    input  logic [cfe_pkg::KEY_W-1:0]  i_key,
    input  logic                       i_evict_second,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_ok,
    output logic [cfe_pkg::CNT_W-1:0]  o_relocations_used
);

    cfe_pkg::t_cmd cmd;
    cfe_pkg::t_sts sts;

    cfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cfe_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_op               (i_op),
        .i_key              (i_key),
        .i_evict_second     (i_evict_second),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_ok               (o_ok),
        .o_relocations_used (o_relocations_used)
    );

endmodule
